>>> design/c8fd_pkg.sv
// ----------------------------------------------------------------------------
// c8fd_pkg
// Shared types, constants and the CRC-8 byte step for the frame deframer.
// ----------------------------------------------------------------------------
package c8fd_pkg;

	// Framing characters
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_BANG   = 8'h21;
	localparam logic [7:0] CHAR_LF     = 8'h0A;

	// Frame buffer depth default
	localparam int DEF_BUF_DEPTH = 32;

	// Configuration port
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 4'd1;
	localparam logic [5:0] MAX_LEN_RST  = 6'd32;
	localparam logic [7:0] CRC_POLY_RST = 8'h07;

	// Error counters
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Control sequencer
	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_CRC_RD  = 9'b000000010,
		ST_CRC_ACC = 9'b000000100,
		ST_CRC_CHK = 9'b000001000,
		ST_PRE0    = 9'b000010000,
		ST_PRE1    = 9'b000100000,
		ST_RD      = 9'b001000000,
		ST_MEM     = 9'b010000000,
		ST_TRAIL   = 9'b100000000
	} ctl_state_t;

	// Position within the frame being received
	typedef enum logic [6:0] {
		P_HUNT = 7'b0000001,
		P_BANG = 7'b0000010,
		P_LEN0 = 7'b0000100,
		P_LEN1 = 7'b0001000,
		P_BODY = 7'b0010000,
		P_CRC  = 7'b0100000,
		P_END  = 7'b1000000
	} frm_phase_t;

	// One byte of MSB-first CRC-8, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
		input logic [7:0] b, input logic [7:0] poly);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> design/crc8_frame_receiver_deframer_core.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver_deframer_core
// Hunts a byte stream for '$' '!' len16 body crc8 '\n' frames, buffers the
// body in RAM, checks the CRC and emits good frames or flushes bad ones.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | in        | in_valid / in_ready   | rx_byte
//   out     | out       | out_valid / out_ready | kind, data, last, 3 counters
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte is taken while the sequencer is idle; every word it causes is then
// emitted from its own state ('$', '!', the trailing byte) or after a RAM
// read (a buffered byte). The CRC check walks the buffer byte by byte.
// in_ready is high only while the sequencer is idle; the last word of a
// byte may still sit in the output register then. out_ready low stalls the
// emit states. No clearing pass after reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_deframer_core #(
	parameter int BUF_DEPTH = c8fd_pkg::DEF_BUF_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           kind,
	output logic [7:0]                     data,
	output logic                           last,
	output logic [c8fd_pkg::CNT_W-1:0]     too_big_errors,
	output logic [c8fd_pkg::CNT_W-1:0]     crc_errors,
	output logic [c8fd_pkg::CNT_W-1:0]     suffix_errors,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [c8fd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [c8fd_pkg::CFG_DAT_W-1:0] cfg_data
);

	import c8fd_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);

	// Control state
	ctl_state_t         state_q, state_d;
	frm_phase_t         phase_q, phase_d;
	logic [CW-1:0]      fill_q, fill_d;
	logic [CW-1:0]      len_q, len_d;
	logic [CNT_W-1:0]   too_big_q, too_big_d;
	logic [CNT_W-1:0]   bad_crc_q, bad_crc_d;
	logic [CNT_W-1:0]   bad_end_q, bad_end_d;
	logic               ov_q, ov_d;
	logic [5:0]         max_len_q;
	logic [7:0]         poly_q;

	// Working registers
	logic [7:0]         len_lo_q, len_lo_d;
	logic [7:0]         byte_q, byte_d;
	logic               bang_q, bang_d;
	logic               trail_q, trail_d;
	logic               pkind_q, pkind_d;
	logic [CW-1:0]      mem_cnt_q, mem_cnt_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [7:0]         crc_q, crc_d;

	// Output payload
	logic               o_kind_q, o_last_q;
	logic [7:0]         o_data_q;
	logic [CNT_W-1:0]   o_big_q, o_crc_q, o_end_q;

	// RAM port
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [7:0]         ram_rdata;

	// Emit request
	logic               emit;
	logic               e_kind, e_last;
	logic [7:0]         e_data;

	logic               accept;
	logic               slot_free;
	logic [15:0]        len_full;
	logic               too_big;
	logic [CW-1:0]      fill_inc;
	logic [CW-1:0]      idx_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !ov_q || out_ready;
	assign cfg_ready = 1'b1;

	assign len_full = {rx_byte, len_lo_q};
	assign too_big  = (len_full > {10'd0, max_len_q}) || (len_full > 16'(BUF_DEPTH));
	assign fill_inc = fill_q + CW'(1);
	assign idx_inc  = idx_q + CW'(1);

	c8fd_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Frame parser and emit sequencer
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		fill_d    = fill_q;
		len_d     = len_q;
		too_big_d = too_big_q;
		bad_crc_d = bad_crc_q;
		bad_end_d = bad_end_q;
		len_lo_d  = len_lo_q;
		byte_d    = byte_q;
		bang_d    = bang_q;
		trail_d   = trail_q;
		pkind_d   = pkind_q;
		mem_cnt_d = mem_cnt_q;
		idx_d     = idx_q;
		crc_d     = crc_q;
		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		emit      = 1'b0;
		e_kind    = 1'b0;
		e_data    = byte_q;
		e_last    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					byte_d  = rx_byte;
					idx_d   = '0;
					bang_d  = 1'b0;
					trail_d = 1'b0;
					pkind_d = 1'b0;
					mem_cnt_d = '0;
					unique case (phase_q)
						P_BANG: begin
							if (rx_byte == CHAR_BANG) begin
								phase_d = P_LEN0;
								fill_d  = '0;
							end else begin
								// lone '$': give it back with this byte
								phase_d = P_HUNT;
								trail_d = 1'b1;
								state_d = ST_PRE0;
							end
						end
						P_LEN0: begin
							ram_we    = 1'b1;
							ram_waddr = '0;
							len_lo_d  = rx_byte;
							fill_d    = CW'(1);
							phase_d   = P_LEN1;
						end
						P_LEN1: begin
							ram_we    = 1'b1;
							ram_waddr = AW'(1);
							len_d     = len_full[CW-1:0];
							if (too_big) begin
								if (too_big_q != CNT_MAX) begin
									too_big_d = too_big_q + CNT_W'(1);
								end
								bang_d    = 1'b1;
								mem_cnt_d = CW'(2);
								fill_d    = '0;
								phase_d   = P_HUNT;
								state_d   = ST_PRE0;
							end else begin
								fill_d  = CW'(2);
								phase_d = P_BODY;
							end
						end
						P_BODY: begin
							ram_we = 1'b1;
							fill_d = fill_inc;
							if (fill_inc >= len_q) begin
								phase_d = P_CRC;
							end
						end
						P_CRC: begin
							phase_d = P_END;
							crc_d   = '0;
							state_d = (len_q == '0) ? ST_CRC_CHK : ST_CRC_RD;
						end
						P_END: begin
							phase_d   = P_HUNT;
							mem_cnt_d = fill_q;
							fill_d    = '0;
							if (rx_byte == CHAR_LF) begin
								pkind_d = 1'b1;
								state_d = ST_RD;
							end else begin
								if (bad_end_q != CNT_MAX) begin
									bad_end_d = bad_end_q + CNT_W'(1);
								end
								bang_d  = 1'b1;
								trail_d = 1'b1;
								state_d = ST_PRE0;
							end
						end
						default: begin
							// hunting for '$'
							if (rx_byte == CHAR_DOLLAR) begin
								phase_d = P_BANG;
							end else begin
								phase_d = P_HUNT;
								trail_d = 1'b1;
								state_d = ST_TRAIL;
							end
						end
					endcase
				end
			end
			ST_CRC_RD: begin
				ram_re  = 1'b1;
				state_d = ST_CRC_ACC;
			end
			ST_CRC_ACC: begin
				crc_d   = crc8_byte(crc_q, ram_rdata, poly_q);
				idx_d   = idx_inc;
				state_d = (idx_inc == len_q) ? ST_CRC_CHK : ST_CRC_RD;
			end
			ST_CRC_CHK: begin
				idx_d = '0;
				if (crc_q != byte_q) begin
					if (bad_crc_q != CNT_MAX) begin
						bad_crc_d = bad_crc_q + CNT_W'(1);
					end
					bang_d    = 1'b1;
					trail_d   = 1'b1;
					pkind_d   = 1'b0;
					mem_cnt_d = fill_q;
					fill_d    = '0;
					phase_d   = P_HUNT;
					state_d   = ST_PRE0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PRE0: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_data = CHAR_DOLLAR;
					e_last = !bang_q && (mem_cnt_q == '0) && !trail_q;
					if (bang_q) begin
						state_d = ST_PRE1;
					end else if (mem_cnt_q != '0) begin
						state_d = ST_RD;
					end else if (trail_q) begin
						state_d = ST_TRAIL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PRE1: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_data = CHAR_BANG;
					e_last = (mem_cnt_q == '0) && !trail_q;
					if (mem_cnt_q != '0) begin
						state_d = ST_RD;
					end else if (trail_q) begin
						state_d = ST_TRAIL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_MEM;
			end
			ST_MEM: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_kind = pkind_q;
					e_data = ram_rdata;
					e_last = (idx_inc == mem_cnt_q) && !trail_q;
					idx_d  = idx_inc;
					if (idx_inc != mem_cnt_q) begin
						state_d = ST_RD;
					end else if (trail_q) begin
						state_d = ST_TRAIL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TRAIL: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_data  = byte_q;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register valid
	always_comb begin
		ov_d = ov_q && !out_ready;
		if (emit) begin
			ov_d = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= P_HUNT;
			fill_q    <= '0;
			len_q     <= '0;
			too_big_q <= '0;
			bad_crc_q <= '0;
			bad_end_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			fill_q    <= fill_d;
			len_q     <= len_d;
			too_big_q <= too_big_d;
			bad_crc_q <= bad_crc_d;
			bad_end_q <= bad_end_d;
			ov_q      <= ov_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			poly_q    <= CRC_POLY_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_LEN) begin
				max_len_q <= cfg_data[5:0];
			end else if (cfg_index == REG_CRC_POLY) begin
				poly_q <= cfg_data;
			end
		end
	end

	// Working and payload registers
	always_ff @(posedge clk) begin
		len_lo_q  <= len_lo_d;
		byte_q    <= byte_d;
		bang_q    <= bang_d;
		trail_q   <= trail_d;
		pkind_q   <= pkind_d;
		mem_cnt_q <= mem_cnt_d;
		idx_q     <= idx_d;
		crc_q     <= crc_d;
		if (emit) begin
			o_kind_q <= e_kind;
			o_data_q <= e_data;
			o_last_q <= e_last;
			o_big_q  <= too_big_q;
			o_crc_q  <= bad_crc_q;
			o_end_q  <= bad_end_q;
		end
	end

	assign out_valid      = ov_q;
	assign kind           = o_kind_q;
	assign data           = o_data_q;
	assign last           = o_last_q;
	assign too_big_errors = o_big_q;
	assign crc_errors     = o_crc_q;
	assign suffix_errors  = o_end_q;

endmodule

>>> design/c8fd_ram.sv
// ----------------------------------------------------------------------------
// c8fd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module c8fd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> verif/deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the byte, configuration and result channels of the deframer core.
// It keeps its own copy of the frame state and registers, works out the
// words that each accepted byte must produce, and compares every result
// word field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module deframe_checker #(
	parameter int BUF_DEPTH = c8fd_pkg::DEF_BUF_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           kind,
	input  logic [7:0]                     data,
	input  logic                           last,
	input  logic [c8fd_pkg::CNT_W-1:0]     too_big_errors,
	input  logic [c8fd_pkg::CNT_W-1:0]     crc_errors,
	input  logic [c8fd_pkg::CNT_W-1:0]     suffix_errors,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [c8fd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [c8fd_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);

	import c8fd_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic             last;
		logic [CNT_W-1:0] too_big;
		logic [CNT_W-1:0] bad_crc;
		logic [CNT_W-1:0] bad_end;
	} word_t;

	word_t expected_words[$];
	word_t burst[$];          // words caused by the byte being handled
	word_t got;
	word_t want;

	// Shadow frame state and registers
	frm_phase_t       rx_phase;
	logic [5:0]       lim_len;
	logic [7:0]       poly;
	logic [7:0]       held_bytes [BUF_DEPTH];
	int               held;
	logic [15:0]      len_field;
	logic [CNT_W-1:0] n_too_big;
	logic [CNT_W-1:0] n_bad_crc;
	logic [CNT_W-1:0] n_bad_end;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	task automatic add_word(input logic k, input logic [7:0] b);
		word_t w;
		w = '0;
		w.kind = k;
		w.data = b;
		burst.push_back(w);
	endtask

	task automatic stash(input logic [7:0] b);
		if (held < BUF_DEPTH) begin
			held_bytes[held] = b;
			held++;
		end
	endtask

	// Aborted frame: prefix and everything buffered go out as stray bytes
	task automatic flush_held();
		add_word(1'b0, CHAR_DOLLAR);
		add_word(1'b0, CHAR_BANG);
		for (int i = 0; i < held; i++)
			add_word(1'b0, held_bytes[i]);
		held = 0;
		rx_phase = P_HUNT;
	endtask

	task automatic take_byte(input logic [7:0] c);
		logic [7:0] crc;
		burst.delete();
		case (rx_phase)
			P_BANG: begin
				if (c == CHAR_BANG) begin
					rx_phase = P_LEN0;
					held = 0;
				end else begin
					// second prefix byte missing, even another '$'
					add_word(1'b0, CHAR_DOLLAR);
					add_word(1'b0, c);
					rx_phase = P_HUNT;
				end
			end
			P_LEN0: begin
				held = 0;
				stash(c);
				rx_phase = P_LEN1;
			end
			P_LEN1: begin
				stash(c);
				len_field = {held_bytes[1], held_bytes[0]};
				rx_phase = P_BODY;
				if (len_field > lim_len || len_field > BUF_DEPTH) begin
					n_too_big = sat_inc(n_too_big);
					flush_held();
				end
			end
			P_BODY: begin
				// a body always holds at least three bytes
				stash(c);
				if (held >= len_field || held >= BUF_DEPTH)
					rx_phase = P_CRC;
			end
			P_CRC: begin
				crc = '0;
				for (int i = 0; i < len_field && i < BUF_DEPTH; i++) begin
					crc ^= held_bytes[i];
					for (int k = 0; k < 8; k++)
						crc = crc[7] ? ({crc[6:0], 1'b0} ^ poly) : {crc[6:0], 1'b0};
				end
				rx_phase = P_END;
				if (crc != c) begin
					n_bad_crc = sat_inc(n_bad_crc);
					flush_held();
					add_word(1'b0, c);
				end
			end
			P_END: begin
				if (c == CHAR_LF) begin
					for (int i = 0; i < held; i++)
						add_word(1'b1, held_bytes[i]);
					held = 0;
				end else begin
					// bad terminator: CRC byte is dropped, offending byte sent
					n_bad_end = sat_inc(n_bad_end);
					flush_held();
					add_word(1'b0, c);
				end
				rx_phase = P_HUNT;
			end
			default: begin
				rx_phase = (c == CHAR_DOLLAR) ? P_BANG : P_HUNT;
				if (c != CHAR_DOLLAR)
					add_word(1'b0, c);
			end
		endcase

		// every word carries the counters after this byte
		foreach (burst[j]) begin
			burst[j].last    = (j == burst.size() - 1);
			burst[j].too_big = n_too_big;
			burst[j].bad_crc = n_bad_crc;
			burst[j].bad_end = n_bad_end;
			expected_words.push_back(burst[j]);
		end
	endtask

	// Results are checked before the byte of the same edge is taken:
	// a word can never belong to a byte accepted at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase  = P_HUNT;
			lim_len   = MAX_LEN_RST;
			poly      = CRC_POLY_RST;
			held      = 0;
			len_field = '0;
			n_too_big = '0;
			n_bad_crc = '0;
			n_bad_end = '0;
			errors    = 0;
			expected_words.delete();
			pending   = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {kind, data, last, too_big_errors, crc_errors, suffix_errors};
				if (expected_words.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected word kind=%0d data=%02h last=%0d",
							$time, got.kind, got.data, got.last);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						if (errors < MAX_REPORTS)
							$display("%0t: word mismatch kind/data/last/big/crc/end %s %0d/%02h/%0d/%0d/%0d/%0d %s %0d/%02h/%0d/%0d/%0d/%0d",
								$time, "expected", want.kind, want.data, want.last,
								want.too_big, want.bad_crc, want.bad_end, "got",
								got.kind, got.data, got.last,
								got.too_big, got.bad_crc, got.bad_end);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_LEN)
					lim_len = cfg_data[5:0];
				else if (cfg_index == REG_CRC_POLY)
					poly = cfg_data;
			end
			if (in_valid && in_ready)
				take_byte(rx_byte);
			pending = expected_words.size();
		end
	end

endmodule

>>> verif/crc8_frame_receiver_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_deframer_core_tb
// Feeds the deframer a directed set of frames and stray bytes, then four
// phases of random frames (good, bad CRC, bad terminator, oversize, broken
// prefix, noise) under different register settings and handshake pressure.
// The checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_deframer_core_tb;

	import c8fd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;  // no register behind it
	localparam int SETTLE_CYCLES   = 100;  // covers a full-buffer CRC walk
	localparam int ITEMS_PER_PHASE = 112;

	typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_OVERSIZE} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 kind;
	logic [7:0]           data;
	logic                 last;
	logic [CNT_W-1:0]     too_big_errors;
	logic [CNT_W-1:0]     crc_errors;
	logic [CNT_W-1:0]     suffix_errors;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	int                   errors;
	int                   pending;

	int         in_idle_pct = 0;
	int         out_stall_pct = 0;
	int         sent;
	logic [5:0] cur_max = MAX_LEN_RST;
	logic [7:0] cur_poly = CRC_POLY_RST;

	crc8_frame_receiver_deframer_core dut (.*);
	deframe_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= out_stall_pct);

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// One byte word on the input channel; called and returns at a falling edge
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	// Leaves cfg_valid high; configure lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (idx == REG_MAX_LEN)
			cur_max = val[5:0];
		else if (idx == REG_CRC_POLY)
			cur_poly = val;
	endtask

	task automatic configure(input logic [5:0] max_len, input logic [7:0] poly);
		write_reg(REG_CRC_POLY, poly);
		write_reg(REG_MAX_LEN, {2'b00, max_len});
		cfg_valid <= 1'b0;
	endtask

	// Wait for every expected word, then let a CRC walk finish
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Frame: '$' '!' len_lo len_hi body crc '\n', damaged as asked
	task automatic send_frame(input frame_kind_t fk, input logic [15:0] len);
		logic [7:0] b;
		logic [7:0] crc;
		int         n;
		crc = '0;
		n   = (len < 3) ? 3 : len;
		push_byte(CHAR_DOLLAR);
		push_byte(CHAR_BANG);
		for (int i = 0; i < n; i++) begin
			b = (i == 0) ? len[7:0] : (i == 1) ? len[15:8] : 8'($urandom);
			if (i < len) begin
				crc ^= b;
				for (int k = 0; k < 8; k++)
					crc = crc[7] ? ({crc[6:0], 1'b0} ^ cur_poly) : {crc[6:0], 1'b0};
			end
			push_byte(b);
			if (fk == FR_OVERSIZE && i == 1)
				return;
		end
		if (fk == FR_BAD_CRC) begin
			push_byte(crc ^ 8'($urandom_range(255, 1)));
		end else begin
			push_byte(crc);
			b = 8'($urandom);
			if (b == CHAR_LF)
				b = ~b;
			push_byte((fk == FR_BAD_END) ? b : CHAR_LF);
		end
	endtask

	initial begin
		int          pick;
		logic [15:0] len;
		logic [7:0]  b;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: stray extremes, missing second prefix byte (also '$'),
		// oversize length read as unsigned, short lengths, bad CRC, bad end
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CHAR_DOLLAR);
		push_byte(CHAR_DOLLAR);
		push_byte(CHAR_DOLLAR);
		push_byte(8'h7F);
		send_frame(FR_OVERSIZE, 16'hFFFF);
		send_frame(FR_GOOD, 16'd0);
		send_frame(FR_BAD_CRC, 16'd1);
		send_frame(FR_BAD_END, 16'd2);
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					in_idle_pct = 0;  out_stall_pct = 0;
					configure(6'd32, 8'($urandom));
				end
				1: begin
					in_idle_pct = 65; out_stall_pct = 0;
					write_reg(REG_UNUSED, 8'($urandom));
					configure(6'd3, 8'hFF);
				end
				2: begin
					in_idle_pct = 0;  out_stall_pct = 65;
					configure(6'($urandom_range(32, 3)), 8'h00);
				end
				default: begin
					in_idle_pct = 16; out_stall_pct = 16;
					configure(6'($urandom_range(32, 3)), 8'($urandom));
				end
			endcase

			// Mostly well-formed frames, some damaged ones and noise
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				len  = ($urandom_range(7) == 0) ? 16'(cur_max)
					: 16'($urandom_range((cur_max < 8) ? cur_max : 8));
				if (pick < 55)
					send_frame(FR_GOOD, len);
				else if (pick < 65)
					send_frame(FR_BAD_CRC, len);
				else if (pick < 75)
					send_frame(FR_BAD_END, len);
				else if (pick < 83) begin
					len = $urandom_range(1) ? 16'(cur_max + 1 + $urandom_range(3))
						: 16'($urandom_range(65535, cur_max + 1));
					send_frame(FR_OVERSIZE, len);
				end else if (pick < 90) begin
					b = 8'($urandom);
					if (b == CHAR_BANG)
						b = ~b;
					push_byte(CHAR_DOLLAR);
					push_byte(b);
				end else
					push_byte(8'($urandom));
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
